### hw/rtl/scbs_pkg.sv
package scbs_pkg;

  localparam int SIZE_W      = 38;
  localparam int LEN_W       = 6;
  localparam int CLASS_W     = 10;
  localparam int START_W     = CLASS_W + 1;
  localparam int NUM_CLASSES = 1024;
  localparam int WORD_BITS   = 64;
  localparam int BIT_IDX_W   = 6;
  localparam int WORD_COUNT  = (NUM_CLASSES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W  = $clog2(WORD_COUNT);

  localparam logic [1:0] MODE_MARK   = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASS,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef logic [WORD_BITS-1:0] word_t;

  // Index of the single set bit of a one-hot word (0 when the word is empty).
  function automatic logic [BIT_IDX_W-1:0] onehot_index(input word_t onehot);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        idx = idx | BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### hw/rtl/scbs_class_unit.sv
module scbs_class_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [scbs_pkg::SIZE_W-1:0]  size,
  output logic                         done,
  output logic [scbs_pkg::CLASS_W-1:0] size_class
);

  logic                        busy;
  logic [scbs_pkg::SIZE_W-1:0] x;
  logic [scbs_pkg::LEN_W-1:0]  len;

  // Normalize the size left until the leading one sits at the top bit,
  // four places a step while the top nibble is empty, then one place a step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if (x == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (x[scbs_pkg::SIZE_W-1 -: 4] == 4'd0) begin
        end else if (!x[scbs_pkg::SIZE_W-1]) begin
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= size;
      len <= scbs_pkg::LEN_W'(scbs_pkg::SIZE_W);
    end else if (busy) begin
      if (x == '0) begin
        size_class <= '0;
      end else if (x[scbs_pkg::SIZE_W-1 -: 4] == 4'd0) begin
        x   <= x << 4;
        len <= len - scbs_pkg::LEN_W'(4);
      end else if (!x[scbs_pkg::SIZE_W-1]) begin
        x   <= x << 1;
        len <= len - scbs_pkg::LEN_W'(1);
      end else begin
        // Class is the bit length, then the four bits below the leading one.
        size_class <= scbs_pkg::CLASS_W'({len, x[scbs_pkg::SIZE_W-2 -: 4]});
      end
    end
  end

endmodule

### hw/rtl/size_class_bitmap_search.sv
// Size-class index for a segregated-fit allocator. Each item carries a mode
// and a byte size; the size maps to a class (bit length times 16 plus the four
// bits below the leading one, 0 for size 0). Mode 0 marks that class available,
// mode 1 clears it, mode 2 returns the lowest available class above it, and
// mode 3 only reports the class. Every item gives exactly one result. The
// block takes one item at a time: the class normalizer shifts 4 bits and then
// 1 bit per cycle; a search then scans one 64-bit word of the 1024-bit
// availability bitmap per cycle until it finds a set bit or reaches the last
// word; the result is then presented and held until taken. The bitmap clears
// in the reset cycle, so no warm-up follows reset.
module size_class_bitmap_search (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   mode,
  input  logic [scbs_pkg::SIZE_W-1:0]  size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [scbs_pkg::CLASS_W-1:0] size_class,
  output logic                         found,
  output logic [scbs_pkg::CLASS_W-1:0] found_class
);

  scbs_pkg::state_t state, state_next;

  logic                             accept;
  logic                             cu_done;
  logic [scbs_pkg::CLASS_W-1:0]     cu_class;
  logic [1:0]                       mode_q;
  logic [scbs_pkg::START_W-1:0]     start_cls;
  logic                             start_ok;
  logic [scbs_pkg::WORD_IDX_W-1:0]  blk;
  logic [scbs_pkg::BIT_IDX_W-1:0]   bit_off;
  logic                             first;
  scbs_pkg::word_t                  bitmap [scbs_pkg::WORD_COUNT];
  scbs_pkg::word_t                  scan_word;
  scbs_pkg::word_t                  scan_onehot;
  logic                             scan_hit;
  logic                             scan_last;
  logic [scbs_pkg::CLASS_W-1:0]     cand;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == scbs_pkg::ST_IDLE);
  assign out_valid = (state == scbs_pkg::ST_DONE);

  scbs_class_unit u_class (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .size       (size),
    .done       (cu_done),
    .size_class (cu_class)
  );

  assign start_cls = scbs_pkg::START_W'(cu_class) + scbs_pkg::START_W'(1);
  assign start_ok  = start_cls < scbs_pkg::START_W'(scbs_pkg::NUM_CLASSES);

  // Mask off bits below the start position in the first word only.
  assign scan_word   = bitmap[blk] & (first ? ({scbs_pkg::WORD_BITS{1'b1}} << bit_off)
                                            : {scbs_pkg::WORD_BITS{1'b1}});
  assign scan_onehot = scan_word & (~scan_word + scbs_pkg::WORD_BITS'(1));
  assign scan_hit    = (scan_word != '0);
  assign scan_last   = (blk == scbs_pkg::WORD_IDX_W'(scbs_pkg::WORD_COUNT - 1));
  assign cand        = scbs_pkg::CLASS_W'({blk, scbs_pkg::onehot_index(scan_onehot)});

  always_comb begin
    state_next = state;
    unique case (state)
      scbs_pkg::ST_IDLE: begin
        if (accept) state_next = scbs_pkg::ST_CLASS;
      end
      scbs_pkg::ST_CLASS: begin
        if (cu_done) begin
          if (mode_q == scbs_pkg::MODE_SEARCH && start_ok) begin
            state_next = scbs_pkg::ST_SCAN;
          end else begin
            state_next = scbs_pkg::ST_DONE;
          end
        end
      end
      scbs_pkg::ST_SCAN: begin
        if (scan_hit || scan_last) state_next = scbs_pkg::ST_DONE;
      end
      scbs_pkg::ST_DONE: begin
        if (out_ready) state_next = scbs_pkg::ST_IDLE;
      end
      default: state_next = scbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < scbs_pkg::WORD_COUNT; i++) begin
        bitmap[i] <= '0;
      end
    end else if (state == scbs_pkg::ST_CLASS && cu_done &&
                 scbs_pkg::START_W'(cu_class) < scbs_pkg::START_W'(scbs_pkg::NUM_CLASSES)) begin
      if (mode_q == scbs_pkg::MODE_MARK) begin
        bitmap[cu_class[scbs_pkg::BIT_IDX_W +: scbs_pkg::WORD_IDX_W]]
          [cu_class[scbs_pkg::BIT_IDX_W-1:0]] <= 1'b1;
      end else if (mode_q == scbs_pkg::MODE_CLEAR) begin
        bitmap[cu_class[scbs_pkg::BIT_IDX_W +: scbs_pkg::WORD_IDX_W]]
          [cu_class[scbs_pkg::BIT_IDX_W-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
    end
    if (state == scbs_pkg::ST_CLASS && cu_done) begin
      size_class  <= cu_class;
      found       <= 1'b0;
      found_class <= '0;
      blk         <= start_cls[scbs_pkg::BIT_IDX_W +: scbs_pkg::WORD_IDX_W];
      bit_off     <= start_cls[scbs_pkg::BIT_IDX_W-1:0];
      first       <= 1'b1;
    end
    if (state == scbs_pkg::ST_SCAN) begin
      first <= 1'b0;
      if (scan_hit) begin
        // Drop a hit that lands past the last class.
        if (scbs_pkg::START_W'(cand) < scbs_pkg::START_W'(scbs_pkg::NUM_CLASSES)) begin
          found       <= 1'b1;
          found_class <= cand;
        end
      end else if (!scan_last) begin
        blk <= blk + scbs_pkg::WORD_IDX_W'(1);
      end
    end
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("accepted item did not leave idle");

  a_out_not_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is held");

  a_found_above: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (found_class > size_class))
    else $error("found class not above the size class");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (found_class == '0))
    else $error("found class nonzero without a hit");

  a_class_done_state: assert property (@(posedge clk) disable iff (rst)
    cu_done |-> (state == scbs_pkg::ST_CLASS))
    else $error("class unit finished outside the class phase");

endmodule

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_NONE = 2'd3;  // unused code: reports the class only
  localparam int CYCLE_LIMIT = 100000;

  typedef enum int {
    FILL_ANY,
    DRAIN,
    FILL_HIGH
  } regime_t;

  // Tracks the availability bitmap and the queue of results owed by the block.
  class class_index_scoreboard;
    typedef struct packed {
      logic [scbs_pkg::CLASS_W-1:0] cls;
      logic                         hit;
      logic [scbs_pkg::CLASS_W-1:0] hit_cls;
    } result_t;

    logic [scbs_pkg::NUM_CLASSES-1:0] avail_map;
    result_t                          owed[$];
    int                               errors;
    int                               checked;
    int                               marks;
    int                               clears;
    int                               searches;
    int                               hits;
    int                               unused;

    function new();
      avail_map = '0;
      errors    = 0;
      checked   = 0;
      marks     = 0;
      clears    = 0;
      searches  = 0;
      hits      = 0;
      unused    = 0;
    endfunction

    // Bit length times 16, plus the four bits just below the leading one.
    function int class_of_size(logic [scbs_pkg::SIZE_W-1:0] s);
      int                            len;
      logic [scbs_pkg::SIZE_W+4:0]   wide;
      logic [scbs_pkg::SIZE_W+4:0]   shifted;
      len = 0;
      for (int i = 0; i < scbs_pkg::SIZE_W; i++) begin
        if (s[i]) len = i + 1;
      end
      if (len == 0) return 0;
      wide    = {s, 5'b0};
      shifted = wide >> len;
      return (len * 16) + int'(shifted[3:0]);
    endfunction

    function void note_request(logic [1:0] m, logic [scbs_pkg::SIZE_W-1:0] s);
      result_t r;
      int      c;
      c         = class_of_size(s);
      r.cls     = scbs_pkg::CLASS_W'(c);
      r.hit     = 1'b0;
      r.hit_cls = '0;
      case (m)
        scbs_pkg::MODE_MARK: begin
          marks++;
          if (c < scbs_pkg::NUM_CLASSES) avail_map[c] = 1'b1;
        end
        scbs_pkg::MODE_CLEAR: begin
          clears++;
          if (c < scbs_pkg::NUM_CLASSES) avail_map[c] = 1'b0;
        end
        scbs_pkg::MODE_SEARCH: begin
          searches++;
          for (int k = c + 1; k < scbs_pkg::NUM_CLASSES; k++) begin
            if (avail_map[k]) begin
              r.hit     = 1'b1;
              r.hit_cls = scbs_pkg::CLASS_W'(k);
              break;
            end
          end
          if (r.hit) hits++;
        end
        default: unused++;
      endcase
      owed = {owed, r};
    endfunction

    function void check_result(logic [scbs_pkg::CLASS_W-1:0] cls, logic hit,
                               logic [scbs_pkg::CLASS_W-1:0] hit_cls);
      result_t want;
      if (owed.size() == 0) begin
        $error("result with no request pending: size_class=%0d found=%0d found_class=%0d",
               cls, hit, hit_cls);
        errors++;
        return;
      end
      want = owed.pop_front();
      checked++;
      if (cls !== want.cls) begin
        $error("size_class: expected %0d, got %0d", want.cls, cls);
        errors++;
      end
      if (hit !== want.hit) begin
        $error("found: expected %0d, got %0d", want.hit, hit);
        errors++;
      end
      if (hit_cls !== want.hit_cls) begin
        $error("found_class: expected %0d, got %0d", want.hit_cls, hit_cls);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   mode = scbs_pkg::MODE_MARK;
  logic [scbs_pkg::SIZE_W-1:0]  size = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [scbs_pkg::CLASS_W-1:0] size_class;
  logic                         found;
  logic [scbs_pkg::CLASS_W-1:0] found_class;

  class_index_scoreboard sb = new();
  bit                    idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  size_class_bitmap_search dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .size       (size),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .size_class (size_class),
    .found      (found),
    .found_class(found_class)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random size with a bit length in [lo_len, hi_len]; length 0 gives size 0.
  function automatic logic [scbs_pkg::SIZE_W-1:0] rand_size(int lo_len, int hi_len);
    int          len;
    logic [63:0] top;
    len = $urandom_range(hi_len, lo_len);
    if (len == 0) return '0;
    top = 64'd1 << (len - 1);
    return scbs_pkg::SIZE_W'(top | (rand64() & (top - 64'd1)));
  endfunction

  // Some size that maps to class c, or 0 for an unreachable c below 80; classes above 623 give no valid size.
  function automatic logic [scbs_pkg::SIZE_W-1:0] size_for_class(int c);
    int          len;
    logic [63:0] frac;
    logic [63:0] s;
    if (c == 0) return '0;
    len  = c >> 4;
    frac = 64'(c & 15);
    if (len >= 5) begin
      s = (64'd1 << (len - 1)) | (frac << (len - 5)) |
          (rand64() & ((64'd1 << (len - 5)) - 64'd1));
      return scbs_pkg::SIZE_W'(s);
    end
    for (int v = 1; v < 16; v++) begin
      if (sb.class_of_size(scbs_pkg::SIZE_W'(v)) == c) return scbs_pkg::SIZE_W'(v);
    end
    return '0;
  endfunction

  // A currently available class, starting the hunt at a random point; -1 if none.
  function automatic int pick_available();
    int start;
    int c;
    start = $urandom_range(scbs_pkg::NUM_CLASSES - 1, 0);
    for (int i = 0; i < scbs_pkg::NUM_CLASSES; i++) begin
      c = (start + i) % scbs_pkg::NUM_CLASSES;
      if (sb.avail_map[c]) return c;
    end
    return -1;
  endfunction

  task automatic send_request(logic [1:0] m, logic [scbs_pkg::SIZE_W-1:0] s);
    int gap;
    gap = idle_on ? $urandom_range(14, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    size     <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_request(m, s);
  endtask

  // Clear an available class three times in four when there is one, else a random one.
  task automatic clear_some();
    int c;
    c = pick_available();
    if (c >= 0 && $urandom_range(3, 0) != 0) begin
      send_request(scbs_pkg::MODE_CLEAR, size_for_class(c));
    end else begin
      send_request(scbs_pkg::MODE_CLEAR, rand_size(0, scbs_pkg::SIZE_W));
    end
  endtask

  initial begin
    int      gap;
    gap = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(14, 0) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(size_class, found, found_class);
    end
  end

  initial begin
    regime_t                     regime;
    int                          pick;
    int                          waited;
    logic [scbs_pkg::SIZE_W-1:0] all_ones;
    regime   = FILL_ANY;
    pick     = 0;
    waited   = 0;
    all_ones = '1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty map, class 0, extremes, word boundaries, unused mode.
    send_request(scbs_pkg::MODE_SEARCH, '0);
    send_request(MODE_NONE, all_ones);
    send_request(scbs_pkg::MODE_MARK, '0);
    send_request(scbs_pkg::MODE_SEARCH, '0);
    send_request(scbs_pkg::MODE_MARK, scbs_pkg::SIZE_W'(1));
    send_request(scbs_pkg::MODE_SEARCH, '0);
    send_request(scbs_pkg::MODE_MARK, all_ones);
    send_request(scbs_pkg::MODE_SEARCH, scbs_pkg::SIZE_W'(1));
    send_request(scbs_pkg::MODE_SEARCH, all_ones);
    send_request(MODE_NONE, '0);
    send_request(scbs_pkg::MODE_CLEAR, scbs_pkg::SIZE_W'(1));
    send_request(scbs_pkg::MODE_SEARCH, '0);
    send_request(scbs_pkg::MODE_MARK, scbs_pkg::SIZE_W'(127));
    send_request(scbs_pkg::MODE_SEARCH, scbs_pkg::SIZE_W'(64));
    send_request(scbs_pkg::MODE_SEARCH, scbs_pkg::SIZE_W'(126));
    send_request(scbs_pkg::MODE_MARK, scbs_pkg::SIZE_W'(128));
    send_request(scbs_pkg::MODE_SEARCH, scbs_pkg::SIZE_W'(127));
    send_request(scbs_pkg::MODE_CLEAR, all_ones);
    send_request(scbs_pkg::MODE_CLEAR, scbs_pkg::SIZE_W'(127));
    send_request(scbs_pkg::MODE_CLEAR, scbs_pkg::SIZE_W'(128));
    send_request(scbs_pkg::MODE_CLEAR, '0);
    send_request(scbs_pkg::MODE_SEARCH, '0);
    send_request(scbs_pkg::MODE_MARK, 38'h2A_AAAA_AAAA);
    send_request(MODE_NONE, 38'h15_5555_5555);
    send_request(scbs_pkg::MODE_SEARCH, 38'h15_5555_5555);

    // Random: pick filling or draining at random so searches see both dense and
    // nearly empty maps, with long scans over empty words.
    for (int n = 0; n < 1150; n++) begin
      if (n % 128 == 0) begin
        regime  = regime_t'($urandom_range(2, 0));
        idle_on = ($urandom_range(3, 0) != 0);
      end
      pick = $urandom_range(99, 0);
      case (regime)
        FILL_ANY: begin
          if (pick < 45) send_request(scbs_pkg::MODE_MARK, rand_size(0, scbs_pkg::SIZE_W));
          else if (pick < 60) clear_some();
          else if (pick < 95) send_request(scbs_pkg::MODE_SEARCH,
                                           rand_size(0, scbs_pkg::SIZE_W));
          else send_request(MODE_NONE, rand_size(0, scbs_pkg::SIZE_W));
        end
        DRAIN: begin
          if (pick < 10) send_request(scbs_pkg::MODE_MARK, rand_size(0, scbs_pkg::SIZE_W));
          else if (pick < 50) clear_some();
          else if (pick < 95) send_request(scbs_pkg::MODE_SEARCH,
                                           rand_size(0, scbs_pkg::SIZE_W));
          else send_request(MODE_NONE, rand_size(0, scbs_pkg::SIZE_W));
        end
        default: begin
          if (pick < 40) send_request(scbs_pkg::MODE_MARK, rand_size(30, scbs_pkg::SIZE_W));
          else if (pick < 50) clear_some();
          else if (pick < 95) send_request(scbs_pkg::MODE_SEARCH,
                                           rand_size(0, scbs_pkg::SIZE_W));
          else send_request(MODE_NONE, rand_size(0, scbs_pkg::SIZE_W));
        end
      endcase
    end
    in_valid <= 1'b0;

    while (sb.owed.size() != 0 && waited < CYCLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.owed.size() != 0) begin
      $error("%0d results never arrived", sb.owed.size());
      sb.errors++;
    end
    repeat (40) @(posedge clk);

    $display("Run covered %0d marks, %0d clears, %0d unused-mode items and %0d searches",
             sb.marks, sb.clears, sb.unused, sb.searches);
    $display("%0d searches hit an available class; %0d results compared",
             sb.hits, sb.checked);
    if (sb.errors == 0) begin
      $display("size_class_bitmap_search verification clean");
    end else begin
      $display("size_class_bitmap_search verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("size_class_bitmap_search verification failed");
    $finish;
  end

endmodule

### size_class_bitmap_search.f
hw/rtl/scbs_pkg.sv
hw/rtl/scbs_class_unit.sv
hw/rtl/size_class_bitmap_search.sv
bench/tb_top.sv
